// ----- rtl/law_pkg.sv -----
// ----------------------------------------------------------------------------
// Life automaton window package
// Shared word types, register codes, sizes and the Life rule function.
// ----------------------------------------------------------------------------
`default_nettype none

package law_pkg;

  localparam int unsigned CFG_W           = 11;
  localparam int unsigned OUT_ROW_W       = 10;
  localparam int unsigned OUT_COL_W       = 10;
  localparam int unsigned DEF_MAX_COLUMNS = 1024;
  localparam int unsigned DEF_MAX_ROWS    = 1024;
  localparam int unsigned OUT_FIFO_DEPTH  = 8;
  localparam int unsigned BIRTH_COUNT     = 3;
  localparam int unsigned SURVIVE_COUNT   = 2;

  localparam logic [CFG_W-1:0] BOARD_COLUMNS_RESET = 11'd1024;
  localparam logic [CFG_W-1:0] BOARD_ROWS_RESET    = 11'd1024;

  // Configuration register indexes.
  localparam logic REG_BOARD_COLUMNS = 1'b0;
  localparam logic REG_BOARD_ROWS    = 1'b1;

  // Input word codes.
  localparam logic OP_CELL  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic op;
    logic cell_alive;
  } law_in_t;

  typedef struct packed {
    logic                 next_alive;
    logic [OUT_ROW_W-1:0] out_row;
    logic [OUT_COL_W-1:0] out_col;
    logic                 run_end;
    logic                 frame_end;
  } law_out_t;

  // Last valid index for a size register: zero acts as one, oversize as max.
  function automatic int unsigned clamp_last(int unsigned v, int unsigned max_v);
    int unsigned r;
    if (v == 0) begin
      r = 0;
    end else if (v > max_v) begin
      r = max_v - 1;
    end else begin
      r = v - 1;
    end
    return r;
  endfunction

  // B3/S23 rule on a 3x3 window; bit 4 is the center cell.
  function automatic logic life_next(logic [8:0] w);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        n = n + {3'd0, w[i]};
      end
    end
    return (n == 4'(BIRTH_COUNT)) || (w[4] && (n == 4'(SURVIVE_COUNT)));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/law_out_fifo.sv -----
// ----------------------------------------------------------------------------
// Life automaton window result queue
// Takes up to two result words a cycle and hands out one unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module law_out_fifo #(
  parameter int unsigned DEPTH = law_pkg::OUT_FIFO_DEPTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [1:0]                     push_cnt_i,
  input  wire law_pkg::law_out_t              push_a_i,
  input  wire law_pkg::law_out_t              push_b_i,
  output logic [$clog2(DEPTH+1)-1:0]          count_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output law_pkg::law_out_t                   out_data_o
);
  import law_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  law_out_t           entry_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               pop;

  assign pop         = (count_q != '0) && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = entry_q[rd_ptr_q];
  assign count_o     = count_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    count_d  = count_q + CNT_W'(push_cnt_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      entry_q[wr_ptr_q] <= push_a_i;
    end
    if (push_cnt_i == 2'd2) begin
      entry_q[wr_ptr_q + PTR_W'(1)] <= push_b_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/life_automaton_window.sv -----
// ----------------------------------------------------------------------------
// Life automaton window
// One B3/S23 generation over a raster-order cell stream, line stores in RAM.
// ----------------------------------------------------------------------------
// Each line store read is registered; the results then enter the queue.
// Throughput: one input word per cycle unless stalled for queue room; the
// 2-bit line store RAM is read and written at most once per cycle and the
// result queue drains one word a cycle unless the output stalls. Reset
// clears all control state at once; the line store is not cleared, since
// reads for rows above the board are masked to dead cells.
`default_nettype none

module life_automaton_window #(
  parameter int unsigned MAX_COLUMNS = law_pkg::DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = law_pkg::DEF_MAX_ROWS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire law_pkg::law_in_t          in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output law_pkg::law_out_t              out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_index_i,
  input  wire logic [law_pkg::CFG_W-1:0] cfg_data_i
);
  import law_pkg::*;

  // Column index and row count widths follow the board limits.
  localparam int unsigned COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int unsigned QCNT_W = $clog2(OUT_FIFO_DEPTH + 1);

  // Board size, stored as last column index and last row index.
  logic [COL_W-1:0] last_col_q, last_col_d;
  logic [ROW_W-1:0] last_row_q, last_row_d;

  // Raster position of the next expected word and the drain flag.
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             draining_q, draining_d;

  // Line store: bit 1 is the row two above, bit 0 the row just above.
  logic [1:0]       line_mem [MAX_COLUMNS];
  logic [1:0]       rd_q;

  // Second stage: the word whose line store read is in flight.
  logic             s1_valid_q;
  logic [COL_W-1:0] s1_col_q;
  logic [ROW_W-1:0] s1_row_q;
  logic             s1_cur_q;
  logic             s1_last_q;
  logic             s1_drain_q;
  logic             s1_fwd_q;
  logic             s1_fwd_up_q;
  logic             s1_fwd_mid_q;

  logic [8:0]       win_q, win_d;

  logic             take;
  logic             last0;
  logic             cur0;
  logic             fwd0;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W:0]  q_need;

  logic             raw_up, raw_mid, up1, mid1;
  logic [8:0]       w0, w1, w2;
  logic             emit_a, emit_b;
  logic [31:0]      row_m1, col_m1, col_w;
  law_out_t         res_a, res_b, push_a;
  logic [1:0]       push_cnt;

  // --------------------------------------------------------------------------
  // Input side. A word is taken whenever the result queue keeps room for the
  // word in flight and this one (two results each at most). A word of the
  // wrong kind (flush while cells are expected, or the reverse) is taken and
  // dropped without touching any state.
  // --------------------------------------------------------------------------
  assign q_need     = (QCNT_W+1)'(q_count) + (s1_valid_q ? (QCNT_W+1)'(2) : '0);
  assign in_stall_o = (q_need > (QCNT_W+1)'(OUT_FIFO_DEPTH - 2));

  assign take  = in_valid_i && !in_stall_o &&
                 ((in_data_i.op == OP_FLUSH) == draining_q);
  assign last0 = (col_q == last_col_q);
  assign cur0  = draining_q ? 1'b0 : in_data_i.cell_alive;

  // The entry written this cycle by the second stage is read now with its old
  // contents; this only happens on one-column boards, and the fresh values are
  // carried along instead.
  assign fwd0 = s1_valid_q && (s1_col_q == col_q);

  always_comb begin
    last_col_d = last_col_q;
    last_row_d = last_row_q;
    col_d      = col_q;
    row_d      = row_q;
    draining_d = draining_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BOARD_COLUMNS: begin
          last_col_d = COL_W'(clamp_last(32'(cfg_data_i), MAX_COLUMNS));
        end
        REG_BOARD_ROWS: begin
          last_row_d = ROW_W'(clamp_last(32'(cfg_data_i), MAX_ROWS));
        end
        default: begin
        end
      endcase
      // Any write restarts the frame.
      col_d      = '0;
      row_d      = '0;
      draining_d = 1'b0;
    end else if (take) begin
      if (!last0) begin
        col_d = col_q + COL_W'(1);
      end else begin
        col_d = '0;
        if (draining_q) begin
          row_d      = '0;
          draining_d = 1'b0;
        end else begin
          row_d = row_q + ROW_W'(1);
          if (row_q == last_row_q) begin
            draining_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= COL_W'(clamp_last(32'(BOARD_COLUMNS_RESET), MAX_COLUMNS));
      last_row_q <= ROW_W'(clamp_last(32'(BOARD_ROWS_RESET), MAX_ROWS));
      col_q      <= '0;
      row_q      <= '0;
      draining_q <= 1'b0;
      s1_valid_q <= 1'b0;
      win_q      <= '0;
    end else begin
      last_col_q <= last_col_d;
      last_row_q <= last_row_d;
      col_q      <= col_d;
      row_q      <= row_d;
      draining_q <= draining_d;
      s1_valid_q <= take;
      win_q      <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_col_q     <= col_q;
      s1_row_q     <= row_q;
      s1_cur_q     <= cur0;
      s1_last_q    <= last0;
      s1_drain_q   <= draining_q;
      s1_fwd_q     <= fwd0;
      s1_fwd_up_q  <= mid1;
      s1_fwd_mid_q <= s1_cur_q;
    end
  end

  // --------------------------------------------------------------------------
  // Line store RAM: registered read on the first stage, write back of the
  // shifted column on the second stage.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (take) begin
      rd_q <= line_mem[col_q];
    end
    if (s1_valid_q) begin
      line_mem[s1_col_q] <= {mid1, s1_cur_q};
    end
  end

  // --------------------------------------------------------------------------
  // Second stage: build the new window column, shift the window and form the
  // results. Rows above the board read as dead, so old RAM contents from an
  // earlier frame never count.
  // --------------------------------------------------------------------------
  always_comb begin
    raw_up  = s1_fwd_q ? s1_fwd_up_q  : rd_q[1];
    raw_mid = s1_fwd_q ? s1_fwd_mid_q : rd_q[0];
    up1     = (s1_row_q >= ROW_W'(2)) ? raw_up  : 1'b0;
    mid1    = (s1_row_q >= ROW_W'(1)) ? raw_mid : 1'b0;

    // The window restarts empty at every row start, giving a dead left border.
    w0 = (s1_col_q == '0) ? 9'd0 : win_q;
    w1 = {s1_cur_q, mid1, up1, w0[8:3]};
    // At the row end one more dead column is shifted in for the last cell.
    w2 = {3'b000, w1[8:3]};

    win_d = win_q;
    if (cfg_we_i) begin
      win_d = '0;
    end else if (s1_valid_q) begin
      win_d = s1_last_q ? w2 : w1;
    end
  end

  always_comb begin
    row_m1 = 32'(s1_row_q) - 32'd1;
    col_m1 = 32'(s1_col_q) - 32'd1;
    col_w  = 32'(s1_col_q);

    emit_a = s1_valid_q && (s1_row_q != '0) && (s1_col_q != '0);
    emit_b = s1_valid_q && (s1_row_q != '0) && s1_last_q;

    res_a.next_alive = life_next(w1);
    res_a.out_row    = row_m1[OUT_ROW_W-1:0];
    res_a.out_col    = col_m1[OUT_COL_W-1:0];
    res_a.run_end    = !s1_last_q;
    res_a.frame_end  = 1'b0;

    res_b.next_alive = life_next(w2);
    res_b.out_row    = row_m1[OUT_ROW_W-1:0];
    res_b.out_col    = col_w[OUT_COL_W-1:0];
    res_b.run_end    = 1'b1;
    res_b.frame_end  = s1_drain_q;

    push_a   = emit_a ? res_a : res_b;
    push_cnt = 2'({1'b0, emit_a}) + 2'({1'b0, emit_b});
  end

  // --------------------------------------------------------------------------
  // Result queue: parts the computing stages from the output handshake.
  // --------------------------------------------------------------------------
  law_out_fifo #(
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push_a_i    (push_a),
    .push_b_i    (res_b),
    .count_o     (q_count),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  // The raster column never passes the last column of the board.
  a_col_in_board: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= last_col_q)
    else $error("column position beyond board width");

  // Draining only ever follows the last board row.
  a_drain_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draining_q |-> (32'(row_q) == 32'(last_row_q) + 32'd1))
    else $error("drain flag set away from the row below the board");

  // The reserve on the input side keeps the result queue from overflowing.
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(q_count) + 32'(push_cnt) <= 32'(OUT_FIFO_DEPTH))
    else $error("result queue overflow");

  // A result that ends the frame always ends its run too.
  a_frame_end_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.frame_end) |-> out_data_o.run_end)
    else $error("frame end without run end");
`endif

endmodule

`default_nettype wire
